### rtl/vws_pkg.sv
`default_nettype none
package vws_pkg;

  localparam int WinLen = 16;
  localparam int IdxBits = 4;
  localparam int MagBits = 32;
  localparam int CoefBits = 16;

  // Operation codes of an input item.
  localparam logic OpPush = 1'b0;
  localparam logic OpCompute = 1'b1;

  // Datapath commands issued by the controller.
  typedef enum logic [2:0] {
    CmdNone,
    CmdPush,
    CmdSumStep,
    CmdMacClear,
    CmdMacStep,
    CmdMagStart,
    CmdSqrtStep,
    CmdSmooth
  } cmd_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [IdxBits-1:0] n;
    logic [IdxBits-1:0] k;
  } ctrl_t;

  typedef struct packed {
    logic sqrt_done;
  } stat_t;

  // Twiddles of k*pi/8 in Q1.15, plus one sign bit of headroom.
  function automatic logic signed [17:0] cos_q15(input logic [IdxBits-1:0] m);
    logic signed [17:0] r;
    case (m)
      4'd0: r = 18'sd32768;
      4'd1: r = 18'sd30274;
      4'd2: r = 18'sd23170;
      4'd3: r = 18'sd12540;
      4'd4: r = 18'sd0;
      4'd5: r = -18'sd12540;
      4'd6: r = -18'sd23170;
      4'd7: r = -18'sd30274;
      4'd8: r = -18'sd32768;
      4'd9: r = -18'sd30274;
      4'd10: r = -18'sd23170;
      4'd11: r = -18'sd12540;
      4'd12: r = 18'sd0;
      4'd13: r = 18'sd12540;
      4'd14: r = 18'sd23170;
      default: r = 18'sd30274;
    endcase
    return r;
  endfunction

  function automatic logic signed [17:0] sin_q15(input logic [IdxBits-1:0] m);
    return cos_q15(m - 4'd4);
  endfunction

endpackage
`default_nettype wire

### rtl/vws_datapath.sv
`default_nettype none
module vws_datapath #(
  parameter int VALUE_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire vws_pkg::ctrl_t      ctrl_i,
  output vws_pkg::stat_t           stat_o,
  input  wire logic [15:0]         volume_value_i,
  input  wire logic [15:0]         coef_i,
  output logic [15:0]              avg_o,
  output logic [31:0]              mag_o
);
  import vws_pkg::*;

  localparam int SumBits = VALUE_BITS + IdxBits;
  localparam int AccBits = VALUE_BITS + 24;

  // Ring storage, cleared at reset by valid bits.
  logic [VALUE_BITS-1:0] ring_q [WinLen];
  logic [WinLen-1:0]     vld_q;
  logic [IdxBits-1:0]    wptr_q;
  logic [SumBits-1:0]    sum_q;
  logic signed [AccBits-1:0] re_q, im_q;
  logic [63:0]           rad_q, res_q, bit_q;
  logic [5:0]            sstep_q;
  logic                  sat_q;
  logic [31:0]           sbin_q [WinLen];
  logic [WinLen-1:0]     sbv_q;
  logic [31:0]           mag_q;

  logic [IdxBits-1:0]    rd_idx;
  logic [VALUE_BITS-1:0] x;
  logic [IdxBits-1:0]    m;
  logic signed [AccBits-1:0] pre, pim;
  logic [AccBits-1:0]    are, aim;
  logic [AccBits-8:0]    a, b;
  logic [31:0]           a_lo, b_lo;
  logic [64:0]           sq_sum;
  logic [63:0]           trial;
  logic [63:0]           res_nxt;
  logic [31:0]           old;
  logic [47:0]           fb;
  logic [32:0]           tot;
  logic [SumBits-1:0]    sum_nxt;
  logic [SumBits-IdxBits-1:0] mean;

  // Operand selection for the ring sweep and the MAC.
  always_comb begin
    rd_idx = (ctrl_i.cmd == CmdSumStep) ? ctrl_i.n : wptr_q + ctrl_i.n;
    x = vld_q[rd_idx] ? ring_q[rd_idx] : '0;
    m = ctrl_i.n * ctrl_i.k;
    pre = AccBits'($signed({1'b0, x}) * cos_q15(m));
    pim = AccBits'($signed({1'b0, x}) * sin_q15(m));
    are = re_q[AccBits-1] ? AccBits'(-re_q) : AccBits'(re_q);
    aim = im_q[AccBits-1] ? AccBits'(-im_q) : AccBits'(im_q);
    a = are[AccBits-1:7];
    b = aim[AccBits-1:7];
    // Squares only matter below 2^32; wider operands saturate anyway.
    a_lo = 32'(a);
    b_lo = 32'(b);
    sq_sum = {1'b0, 64'(a_lo) * 64'(a_lo)} + {1'b0, 64'(b_lo) * 64'(b_lo)};
    trial = res_q + bit_q;
    res_nxt = (rad_q >= trial) ? (res_q >> 1) + bit_q : res_q >> 1;
    old = sbv_q[ctrl_i.k] ? sbin_q[ctrl_i.k] : '0;
    fb = old * coef_i;
    tot = {1'b0, mag_q} + 33'(fb[47:16]);
    // The last sweep cycle adds its entry here, so the mean is complete.
    sum_nxt = sum_q + SumBits'(x);
    mean = sum_nxt[SumBits-1:IdxBits];
  end

  // Average saturates when the value width exceeds 16 bits.
  always_comb begin
    if (SumBits - IdxBits > 16 && (mean >> 16) != 0) avg_o = 16'hFFFF;
    else avg_o = 16'(mean);
  end

  // Sequenced datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      sbv_q <= '0;
      wptr_q <= '0;
    end else begin
      case (ctrl_i.cmd)
        CmdPush: begin
          ring_q[wptr_q] <= VALUE_BITS'(volume_value_i);
          vld_q[wptr_q] <= 1'b1;
          sum_q <= '0;
        end
        CmdSumStep: begin
          sum_q <= sum_nxt;
          if (ctrl_i.n == IdxBits'(WinLen - 1)) wptr_q <= wptr_q + 1'b1;
        end
        CmdMacClear: begin
          re_q <= '0;
          im_q <= '0;
        end
        CmdMacStep: begin
          re_q <= re_q + pre;
          im_q <= im_q - pim;
        end
        CmdMagStart: begin
          rad_q <= sq_sum[63:0];
          sat_q <= ((a >> 32) != 0) || ((b >> 32) != 0) || sq_sum[64];
          res_q <= '0;
          bit_q <= 64'd1 << 62;
          sstep_q <= '0;
        end
        CmdSqrtStep: begin
          if (rad_q >= trial) begin
            rad_q <= rad_q - trial;
          end
          res_q <= res_nxt;
          bit_q <= bit_q >> 2;
          sstep_q <= sstep_q + 1'b1;
          if (sstep_q == 6'd31) mag_q <= sat_q ? 32'hFFFFFFFF : 32'(res_nxt);
        end
        CmdSmooth: begin
          sbin_q[ctrl_i.k] <= tot[32] ? 32'hFFFFFFFF : tot[31:0];
          sbv_q[ctrl_i.k] <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign stat_o.sqrt_done = (sstep_q == 6'd32);
  assign mag_o = tot[32] ? 32'hFFFFFFFF : tot[31:0];

endmodule
`default_nettype wire

### rtl/vws_ctrl.sv
`default_nettype none
module vws_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic           operation_i,
  input  wire vws_pkg::stat_t stat_i,
  output vws_pkg::ctrl_t      ctrl_o,
  output logic                busy_o,
  output logic                push_done_o,
  output logic                bin_done_o
);
  import vws_pkg::*;

  typedef enum logic [2:0] {
    Idle, Sum, MacClr, Mac, MagStart, Sqrt, Smooth
  } state_e;

  state_e state_q;
  logic [IdxBits-1:0] n_q, k_q;

  // Command decode from state.
  always_comb begin
    ctrl_o.n = n_q;
    ctrl_o.k = k_q;
    case (state_q)
      Idle: ctrl_o.cmd = (start_i && operation_i == OpPush) ? CmdPush : CmdNone;
      Sum: ctrl_o.cmd = CmdSumStep;
      MacClr: ctrl_o.cmd = CmdMacClear;
      Mac: ctrl_o.cmd = CmdMacStep;
      MagStart: ctrl_o.cmd = CmdMagStart;
      Sqrt: ctrl_o.cmd = stat_i.sqrt_done ? CmdNone : CmdSqrtStep;
      Smooth: ctrl_o.cmd = CmdSmooth;
      default: ctrl_o.cmd = CmdNone;
    endcase
  end

  assign busy_o = (state_q != Idle);
  assign push_done_o = (state_q == Sum) && (n_q == IdxBits'(WinLen - 1));
  assign bin_done_o = (state_q == Smooth);

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      n_q <= '0;
      k_q <= '0;
    end else begin
      case (state_q)
        Idle: begin
          n_q <= '0;
          k_q <= '0;
          if (start_i) state_q <= (operation_i == OpPush) ? Sum : MacClr;
        end
        Sum: begin
          n_q <= n_q + 1'b1;
          if (n_q == IdxBits'(WinLen - 1)) state_q <= Idle;
        end
        MacClr: begin
          n_q <= '0;
          state_q <= Mac;
        end
        Mac: begin
          n_q <= n_q + 1'b1;
          if (n_q == IdxBits'(WinLen - 1)) state_q <= MagStart;
        end
        MagStart: state_q <= Sqrt;
        Sqrt: if (stat_i.sqrt_done) state_q <= Smooth;
        Smooth: begin
          k_q <= k_q + 1'b1;
          state_q <= (k_q == IdxBits'(WinLen - 1)) ? Idle : MacClr;
        end
        default: state_q <= Idle;
      endcase
    end
  end

  a_busy_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("start not taken");
  a_bin_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bin_done_o |=> !bin_done_o) else $error("bins back to back");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_done_o && bin_done_o)) else $error("two results at once");
endmodule
`default_nettype wire

### rtl/volume_window_spectrum.sv
`default_nettype none
// Volume ring with running mean and a smoothed 16-point spectrum. A push holds
// busy_o while it sums the ring (one ring read per cycle) and gives one result
// in the cycle after the last read. A compute gives 16 results, one per bin,
// each after a clear state, a MAC sweep over the 16 ring entries, a setup state,
// a 32-step bit-serial square root plus a state to finish it, and the smoothing
// state. Results are strobed by valid_o for one cycle and cannot be stalled;
// start_i is taken only while busy_o is low.
module volume_window_spectrum #(
  parameter int VALUE_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        operation_i,
  input  wire logic [15:0] volume_value_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,
  output logic             valid_o,
  output logic [15:0]      window_average_o,
  output logic [3:0]       bin_index_o,
  output logic [31:0]      smoothed_magnitude_o,
  output logic             last_result_o
);
  import vws_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic [15:0] coef_q, avg;
  logic [31:0] mag;
  logic push_done, bin_done;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) coef_q <= '0;
    else if (cfg_valid_i) coef_q <= cfg_data_i;
  end

  vws_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .operation_i, .stat_i(stat), .ctrl_o(ctrl),
    .busy_o, .push_done_o(push_done), .bin_done_o(bin_done)
  );

  vws_datapath #(.VALUE_BITS(VALUE_BITS)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat), .volume_value_i,
    .coef_i(coef_q), .avg_o(avg), .mag_o(mag)
  );

  // Output register: one-cycle result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
      last_result_o <= 1'b0;
    end else begin
      valid_o <= push_done | bin_done;
      last_result_o <= push_done | (bin_done && ctrl.k == IdxBits'(WinLen - 1));
    end
  end
  always_ff @(posedge clk_i) begin
    window_average_o <= push_done ? avg : 16'd0;
    bin_index_o <= push_done ? 4'd0 : ctrl.k;
    smoothed_magnitude_o <= push_done ? 32'd0 : mag;
  end
endmodule
`default_nettype wire

### sim/volume_window_spectrum_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module volume_window_spectrum_tb;
  import vws_pkg::*;

  localparam int CycleLimit = 1200000;

  // One expected result transaction.
  typedef struct {
    logic [15:0] average;
    logic [3:0]  bin;
    logic [31:0] magnitude;
    logic        last;
  } spectrum_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        operation_i;
  logic [15:0] volume_value_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;
  logic        valid_o;
  logic [15:0] window_average_o;
  logic [3:0]  bin_index_o;
  logic [31:0] smoothed_magnitude_o;
  logic        last_result_o;

  // Predictor state.
  logic [15:0] model_ring [WinLen];
  logic [3:0]  model_wptr;
  logic [31:0] model_bins [WinLen];
  logic [15:0] model_coef;

  spectrum_result_t expected_results[$];
  int  error_count;
  int  push_count;
  int  compute_count;
  int  result_count;
  int  cycle_count;
  bit  no_idle;

  volume_window_spectrum dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .operation_i, .volume_value_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i, .valid_o, .window_average_o,
    .bin_index_o, .smoothed_magnitude_o, .last_result_o
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Twiddle tables in Q1.15.
  function automatic longint twiddle_cos(input int m);
    longint t [16] = '{32768, 30274, 23170, 12540, 0, -12540, -23170, -30274,
                       -32768, -30274, -23170, -12540, 0, 12540, 23170, 30274};
    return t[m & 15];
  endfunction

  function automatic longint twiddle_sin(input int m);
    return twiddle_cos(m - 4);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Raw DFT magnitude of bin k over the ring, oldest entry first.
  function automatic logic [31:0] bin_magnitude(input int k);
    longint re;
    longint im;
    longint x;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] a2;
    logic [63:0] s;
    re = 0;
    im = 0;
    for (int n = 0; n < WinLen; n++) begin
      x = longint'(model_ring[(model_wptr + n) & 15]);
      re += x * twiddle_cos(n * k);
      im -= x * twiddle_sin(n * k);
    end
    a = (re < 0 ? -re : re) >> 7;
    b = (im < 0 ? -im : im) >> 7;
    if (a >= 64'h1_0000_0000 || b >= 64'h1_0000_0000) return 32'hFFFF_FFFF;
    a2 = a * a;
    s = a2 + b * b;
    if (s < a2) return 32'hFFFF_FFFF;
    return 32'(int_sqrt(s));
  endfunction

  // Works out the results of one accepted item and queues them.
  task automatic predict_item(input logic op, input logic [15:0] value);
    spectrum_result_t r;
    logic [31:0] sum;
    logic [63:0] total;
    if (op == OpPush) begin
      model_ring[model_wptr] = value;
      sum = 0;
      for (int i = 0; i < WinLen; i++) sum += model_ring[i];
      model_wptr = model_wptr + 1'b1;
      r = '{average: sum[19:4], bin: 4'd0, magnitude: 32'd0, last: 1'b1};
      expected_results.push_back(r);
    end else begin
      for (int k = 0; k < WinLen; k++) begin
        total = 64'(bin_magnitude(k)) + ((64'(model_coef) * model_bins[k]) >> 16);
        if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
        model_bins[k] = total[31:0];
        r = '{average: 16'd0, bin: 4'(k), magnitude: total[31:0], last: k == WinLen - 1};
        expected_results.push_back(r);
      end
    end
  endtask

  // Random gap before a transaction, unless idling is switched off.
  // Start stays high between back-to-back items and drops for a gap or a drain.
  task automatic random_gap();
    if (!no_idle && $urandom_range(99) < 25) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 25);
    end
  endtask

  // Sends one item through the start/busy handshake.
  task automatic send_item(input logic op, input logic [15:0] value);
    random_gap();
    start_i <= 1'b1;
    operation_i <= op;
    volume_value_i <= value;
    do @(posedge clk_i); while (busy_o);
    predict_item(op, value);
    if (op == OpPush) push_count++;
    else compute_count++;
  endtask

  // Waits until every expectation is met, then lets the block settle.
  task automatic drain();
    start_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_coefficient(input logic [15:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    model_coef = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Compares each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    spectrum_result_t e;
    if (rst_ni && valid_o) begin
      result_count++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result avg=%h bin=%0d mag=%h", $time,
                 window_average_o, bin_index_o, smoothed_magnitude_o);
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (window_average_o !== e.average) begin
          $display("%0t: window_average expected %h actual %h", $time, e.average,
                   window_average_o);
          error_count++;
        end
        if (bin_index_o !== e.bin) begin
          $display("%0t: bin_index expected %0d actual %0d", $time, e.bin, bin_index_o);
          error_count++;
        end
        if (smoothed_magnitude_o !== e.magnitude) begin
          $display("%0t: smoothed_magnitude expected %h actual %h", $time, e.magnitude,
                   smoothed_magnitude_o);
          error_count++;
        end
        if (last_result_o !== e.last) begin
          $display("%0t: last_result expected %b actual %b", $time, e.last,
                   last_result_o);
          error_count++;
        end
      end
    end
  end

  // Ends the run once the cycle limit is passed.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Empty ring, then full-scale and zero samples, with spectra in between.
  task automatic test_extremes();
    send_item(OpCompute, 16'h0000);
    send_item(OpPush, 16'hFFFF);
    send_item(OpCompute, 16'hFFFF);
    for (int i = 0; i < 15; i++) send_item(OpPush, 16'hFFFF);
    send_item(OpCompute, 16'h1234);
    send_item(OpPush, 16'h0000);
    send_item(OpPush, 16'h5555);
    send_item(OpPush, 16'hAAAA);
    send_item(OpCompute, 16'h0000);
  endtask

  // Maximum feedback with a full-scale ring drives the sum into saturation.
  task automatic test_saturation();
    write_coefficient(16'hFFFF);
    for (int i = 0; i < 16; i++) send_item(OpPush, (i % 2) ? 16'hFFFF : 16'h0000);
    for (int i = 0; i < 4; i++) send_item(OpCompute, 16'h0000);
    for (int i = 0; i < 16; i++) send_item(OpPush, 16'hFFFF);
    for (int i = 0; i < 20; i++) send_item(OpCompute, 16'h0000);
  endtask

  // Random pushes with occasional spectra, over several coefficients.
  task automatic test_random(input int count);
    logic [15:0] value;
    for (int i = 0; i < count; i++) begin
      if (i % 70 == 0) write_coefficient(16'($urandom_range(65535)));
      if (i % 60 == 20) no_idle = 1'b1;
      if (i % 60 == 40) no_idle = 1'b0;
      case ($urandom_range(3))
        0: value = 16'($urandom_range(65535));
        1: value = 16'($urandom_range(255));
        2: value = 16'hFF00 | 16'($urandom_range(255));
        default: value = 16'(1 << $urandom_range(15));
      endcase
      send_item($urandom_range(11) == 0 ? OpCompute : OpPush, value);
    end
  endtask

  initial begin
    for (int i = 0; i < WinLen; i++) begin
      model_ring[i] = '0;
      model_bins[i] = '0;
    end
    model_wptr = '0;
    model_coef = '0;
    error_count = 0;
    push_count = 0;
    compute_count = 0;
    result_count = 0;
    cycle_count = 0;
    no_idle = 1'b0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    operation_i = OpPush;
    volume_value_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_saturation();
    write_coefficient(16'h0000);
    test_random(150);
    write_coefficient(16'h8000);
    test_random(120);
    drain();
    repeat (900) @(posedge clk_i);

    $display("Covered %0d pushes and %0d spectrum requests, %0d results checked.",
             push_count, compute_count, result_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", error_count,
               expected_results.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
rtl/vws_pkg.sv
rtl/vws_datapath.sv
rtl/vws_ctrl.sv
rtl/volume_window_spectrum.sv
sim/volume_window_spectrum_tb.sv
